FILE: src/mqd_pkg.sv
// Shared types, codes and constants for the MQTT fixed-header deframer.
// Used by mqd_in_stage, mqd_parser and mqtt_packet_deframer; depends on nothing.
`default_nettype none

package mqd_pkg;

  // Largest header plus body that the receive side can hold, in bytes
  localparam int RX_CAPACITY = 512;

  // Width of the decoded remaining length
  localparam int LEN_W = 28;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;

  // Event codes
  localparam logic [2:0] EV_CONNACK  = 3'd0;
  localparam logic [2:0] EV_PINGRESP = 3'd1;
  localparam logic [2:0] EV_PUBLISH  = 3'd2;
  localparam logic [2:0] EV_ACK      = 3'd3;
  localparam logic [2:0] EV_OVERSIZE = 3'd4;
  localparam logic [2:0] EV_PROTO    = 3'd5;

  // Input operations
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Packet type nibbles
  localparam logic [3:0] TYPE_CONNACK  = 4'h2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
  localparam logic [3:0] TYPE_PUBACK   = 4'h4;
  localparam logic [3:0] TYPE_SUBACK   = 4'h9;
  localparam logic [3:0] TYPE_UNSUBACK = 4'hB;
  localparam logic [3:0] TYPE_PINGRESP = 4'hD;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [3:0]       packet_type;
    logic [3:0]       packet_flags;
    logic [7:0]       connack_code;
    logic [LEN_W-1:0] body_length;
  } out_item_t;

  // Result of one parser step
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  // Classify a complete packet that fits the receive buffer
  function automatic logic [2:0] classify_event(input logic [3:0] ptype,
                                                input logic [LEN_W-1:0] len);
    logic [2:0] ev;
    unique case (ptype)
      TYPE_CONNACK:  ev = (len < LEN_W'(2)) ? EV_PROTO : EV_CONNACK;
      TYPE_PINGRESP: ev = EV_PINGRESP;
      TYPE_PUBLISH:  ev = EV_PUBLISH;
      TYPE_PUBACK,
      TYPE_SUBACK,
      TYPE_UNSUBACK: ev = EV_ACK;
      default:       ev = EV_PROTO;
    endcase
    return ev;
  endfunction

endpackage

`default_nettype wire

FILE: src/mqd_in_stage.sv
// Input register of the deframer: holds one accepted word until the parser takes it.
// Depends on mqd_pkg.
`default_nettype none

module mqd_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mqd_pkg::in_item_t in_data,
  input  wire logic             take,
  output logic                  held_valid,
  output mqd_pkg::in_item_t     held_item
);

  // Accept when empty or when the held word leaves this cycle
  assign in_ready = !held_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/mqd_parser.sv
// Fixed-header parser state and its per-byte next-state logic.
// Depends on mqd_pkg.
`default_nettype none

module mqd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire mqd_pkg::in_item_t item,
  output mqd_pkg::step_res_t     res,
  output logic [2:0]             phase
);

  localparam int LW = mqd_pkg::LEN_W;
  localparam logic [LW:0] CapLimit = (LW + 1)'(mqd_pkg::RX_CAPACITY);

  logic [7:0]    header_byte;
  logic [LW-1:0] length_accum;
  logic [1:0]    length_byte_count;
  logic [LW-1:0] body_remaining;
  logic [1:0]    body_bytes_seen;
  logic [7:0]    captured_code;

  logic [2:0]    phase_next;
  logic [7:0]    header_byte_next;
  logic [LW-1:0] length_accum_next;
  logic [1:0]    length_byte_count_next;
  logic [LW-1:0] body_remaining_next;
  logic [1:0]    body_bytes_seen_next;
  logic [7:0]    captured_code_next;

  logic [7:0]    b;
  logic [LW-1:0] group;
  logic [LW-1:0] accum_sum;
  logic [LW:0]   total_len;
  logic [LW-1:0] rem_dec;
  logic [2:0]    ev;

  assign b = item.data_byte;

  // Position the 7-bit length group
  always_comb begin
    unique case (length_byte_count)
      2'd0:    group = LW'(b[6:0]);
      2'd1:    group = LW'(b[6:0]) << 7;
      2'd2:    group = LW'(b[6:0]) << 14;
      default: group = LW'(b[6:0]) << 21;
    endcase
  end

  assign accum_sum = length_accum + group;
  assign total_len = (LW + 1)'(accum_sum) + (LW + 1)'(length_byte_count) + (LW + 1)'(2);
  assign rem_dec   = (body_remaining != '0) ? body_remaining - LW'(1) : body_remaining;

  // Next state and result for one byte
  always_comb begin
    phase_next             = phase;
    header_byte_next       = header_byte;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    body_remaining_next    = body_remaining;
    body_bytes_seen_next   = body_bytes_seen;
    captured_code_next     = captured_code;
    ev                     = mqd_pkg::EV_PROTO;
    res.valid              = 1'b0;

    if (item.op == mqd_pkg::OP_RESTART) begin
      phase_next             = mqd_pkg::PH_HEADER;
      header_byte_next       = '0;
      length_accum_next      = '0;
      length_byte_count_next = '0;
      body_remaining_next    = '0;
      body_bytes_seen_next   = '0;
      captured_code_next     = '0;
    end else begin
      unique case (phase)
        mqd_pkg::PH_HEADER: begin
          header_byte_next       = b;
          length_accum_next      = '0;
          length_byte_count_next = '0;
          body_remaining_next    = '0;
          body_bytes_seen_next   = '0;
          captured_code_next     = '0;
          phase_next             = mqd_pkg::PH_LENGTH;
        end
        mqd_pkg::PH_LENGTH: begin
          length_accum_next = accum_sum;
          if (b[7]) begin
            if (length_byte_count == 2'd3) begin
              phase_next = mqd_pkg::PH_HALT;
              ev         = mqd_pkg::EV_PROTO;
              res.valid  = 1'b1;
            end else begin
              length_byte_count_next = length_byte_count + 2'd1;
            end
          end else if (total_len > CapLimit) begin
            body_remaining_next = accum_sum;
            phase_next = (accum_sum != '0) ? mqd_pkg::PH_SKIP : mqd_pkg::PH_HEADER;
            ev         = mqd_pkg::EV_OVERSIZE;
            res.valid  = 1'b1;
          end else if (accum_sum == '0) begin
            ev         = mqd_pkg::classify_event(header_byte[7:4], accum_sum);
            phase_next = (ev == mqd_pkg::EV_PROTO) ? mqd_pkg::PH_HALT : mqd_pkg::PH_HEADER;
            res.valid  = 1'b1;
          end else begin
            body_remaining_next = accum_sum;
            phase_next          = mqd_pkg::PH_BODY;
          end
        end
        mqd_pkg::PH_BODY: begin
          if (body_bytes_seen == 2'd1) begin
            captured_code_next = b;
          end
          if (body_bytes_seen != 2'd2) begin
            body_bytes_seen_next = body_bytes_seen + 2'd1;
          end
          body_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            ev         = mqd_pkg::classify_event(header_byte[7:4], length_accum);
            phase_next = (ev == mqd_pkg::EV_PROTO) ? mqd_pkg::PH_HALT : mqd_pkg::PH_HEADER;
            res.valid  = 1'b1;
          end
        end
        mqd_pkg::PH_SKIP: begin
          body_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = mqd_pkg::PH_HEADER;
          end
        end
        default: begin
          // halted: drop bytes until restart
        end
      endcase
    end

    // Build the result word
    res.item.event_res    = ev;
    res.item.packet_type  = header_byte[7:4];
    res.item.packet_flags = header_byte[3:0];
    res.item.connack_code = (ev == mqd_pkg::EV_CONNACK) ? captured_code_next : 8'd0;
    res.item.body_length  = length_accum_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mqd_pkg::PH_HEADER;
      header_byte       <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      body_remaining    <= '0;
      body_bytes_seen   <= '0;
      captured_code     <= '0;
    end else if (step) begin
      phase             <= phase_next;
      header_byte       <= header_byte_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      body_remaining    <= body_remaining_next;
      body_bytes_seen   <= body_bytes_seen_next;
      captured_code     <= captured_code_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mqtt_packet_deframer.sv
// MQTT fixed-header deframer: input register, parser, result register.
// Depends on mqd_pkg, mqd_in_stage and mqd_parser.
//
// Usage:
//   The in channel (in_valid/in_ready/in_data) carries one word per cycle
//   while in_ready is high; op selects a received stream byte or a parser
//   restart. The out channel (out_valid/out_ready/out_data) carries at most
//   one event per word: connack, pingresp, publish, ignored ack, oversize
//   drop or protocol error. An event passes from the input register through
//   the parser step into the result register. Throughput: one word per cycle
//   while out_ready stays high, set by the combinational parser step
//   between the input and result registers; words that produce no event
//   still take a parser step. When the receiver stalls with an event pending,
//   the input register takes one more word if empty; in_ready then drops
//   until out_ready returns. Reset (rst, synchronous) empties both registers
//   and returns the parser to waiting for a first header byte. After a
//   protocol error every byte is dropped until a restart word arrives.
`default_nettype none

module mqtt_packet_deframer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mqd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mqd_pkg::out_item_t      out_data
);

  logic               held_valid;
  mqd_pkg::in_item_t  held_item;
  logic               advance;
  mqd_pkg::step_res_t res;
  logic [2:0]         phase;

  // Step the parser when the result register has room
  assign advance = held_valid && (!out_valid || out_ready);

  mqd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mqd_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (held_item),
    .res   (res),
    .phase (phase)
  );

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data <= res.item;
    end
  end

  // Event codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.event_res <= mqd_pkg::EV_PROTO))
    else $error("event code out of range");

  // Only a connack carries a nonzero code
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res != mqd_pkg::EV_CONNACK) |->
      (out_data.connack_code == 8'd0))
    else $error("connack code on non-connack event");

  // Oversize events exceed the receive capacity even with the longest, five-byte header
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == mqd_pkg::EV_OVERSIZE) |->
      ((29'(out_data.body_length) + 29'd5) > 29'(mqd_pkg::RX_CAPACITY)))
    else $error("oversize event for a packet that fits");

  // Halted parser leaves halt only on restart
  assert property (@(posedge clk) disable iff (rst)
    (phase == mqd_pkg::PH_HALT &&
     !(advance && held_item.op == mqd_pkg::OP_RESTART)) |=>
      (phase == mqd_pkg::PH_HALT))
    else $error("parser left halt without restart");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the MQTT fixed-header deframer: directed, capacity and random byte streams,
// checked event by event against a predictor kept in this file. Depends on mqd_pkg and
// mqtt_packet_deframer.
module tb;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_WORDS  = 780;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned LEN_MAX       = 32'h0fff_ffff;
  // A type nibble that MQTT leaves reserved
  localparam logic [3:0]  TYPE_RESERVED = 4'h0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mqd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  mqd_pkg::out_item_t out_data;

  // Parser state as predicted
  logic [2:0]                parse_phase;
  logic [7:0]                hdr_byte;
  logic [mqd_pkg::LEN_W-1:0] len_sum;
  logic [1:0]                len_groups;
  logic [mqd_pkg::LEN_W-1:0] body_left;
  logic [1:0]                body_count;
  logic [7:0]                ack_code;

  mqd_pkg::out_item_t pending_events[$];
  int                 errors = 0;
  int                 words_sent = 0;
  int                 restarts_sent = 0;
  int                 burst_left = 0;
  int                 cycle_count;
  int                 event_tally[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mqtt_packet_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_parser();
    parse_phase = mqd_pkg::PH_HEADER;
    hdr_byte    = '0;
    len_sum     = '0;
    len_groups  = '0;
    body_left   = '0;
    body_count  = '0;
    ack_code    = '0;
  endtask

  task automatic push_event(input logic [2:0] ev, input logic [7:0] code);
    mqd_pkg::out_item_t e;
    e.event_res    = ev;
    e.packet_type  = hdr_byte[7:4];
    e.packet_flags = hdr_byte[3:0];
    e.connack_code = code;
    e.body_length  = len_sum;
    pending_events.push_back(e);
  endtask

  // Classify a packet that fit the receive buffer, on its last byte
  task automatic finish_packet();
    parse_phase = mqd_pkg::PH_HEADER;
    case (hdr_byte[7:4])
      mqd_pkg::TYPE_CONNACK: begin
        if (len_sum < 2) begin
          parse_phase = mqd_pkg::PH_HALT;
          push_event(mqd_pkg::EV_PROTO, 8'h00);
        end else begin
          push_event(mqd_pkg::EV_CONNACK, ack_code);
        end
      end
      mqd_pkg::TYPE_PINGRESP: push_event(mqd_pkg::EV_PINGRESP, 8'h00);
      mqd_pkg::TYPE_PUBLISH:  push_event(mqd_pkg::EV_PUBLISH, 8'h00);
      mqd_pkg::TYPE_PUBACK, mqd_pkg::TYPE_SUBACK, mqd_pkg::TYPE_UNSUBACK:
        push_event(mqd_pkg::EV_ACK, 8'h00);
      default: begin
        parse_phase = mqd_pkg::PH_HALT;
        push_event(mqd_pkg::EV_PROTO, 8'h00);
      end
    endcase
  endtask

  // Advance the predicted parser by one accepted word
  task automatic deframe_step(input mqd_pkg::in_item_t w);
    logic [7:0]  b;
    int unsigned hdr_len;
    b = w.data_byte;
    if (w.op == mqd_pkg::OP_RESTART) begin
      clear_parser();
      return;
    end
    case (parse_phase)
      mqd_pkg::PH_HEADER: begin
        clear_parser();
        hdr_byte    = b;
        parse_phase = mqd_pkg::PH_LENGTH;
      end
      mqd_pkg::PH_LENGTH: begin
        len_sum = len_sum + (mqd_pkg::LEN_W'(b[6:0]) << (7 * len_groups));
        if (b[7]) begin
          if (len_groups == 2'd3) begin
            parse_phase = mqd_pkg::PH_HALT;
            push_event(mqd_pkg::EV_PROTO, 8'h00);
          end else begin
            len_groups = len_groups + 2'd1;
          end
        end else begin
          hdr_len = 2 + len_groups;
          if (hdr_len + len_sum > mqd_pkg::RX_CAPACITY) begin
            body_left   = len_sum;
            parse_phase = (body_left != 0) ? mqd_pkg::PH_SKIP : mqd_pkg::PH_HEADER;
            push_event(mqd_pkg::EV_OVERSIZE, 8'h00);
          end else if (len_sum == 0) begin
            finish_packet();
          end else begin
            body_left   = len_sum;
            parse_phase = mqd_pkg::PH_BODY;
          end
        end
      end
      mqd_pkg::PH_BODY: begin
        if (body_count == 2'd1) ack_code = b;
        if (body_count < 2'd2) body_count = body_count + 2'd1;
        if (body_left != 0) body_left = body_left - 1;
        if (body_left == 0) finish_packet();
      end
      mqd_pkg::PH_SKIP: begin
        if (body_left != 0) body_left = body_left - 1;
        if (body_left == 0) parse_phase = mqd_pkg::PH_HEADER;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  task automatic check_event(input mqd_pkg::out_item_t got);
    mqd_pkg::out_item_t want;
    if (pending_events.size() == 0) begin
      errors++;
      $display("%0t: event with nothing expected, expected none, actual %0d (type %h, len %0d)",
               $time, got.event_res, got.packet_type, got.body_length);
      return;
    end
    want = pending_events.pop_front();
    event_tally[got.event_res]++;
    compare_field("event_res", want.event_res, got.event_res);
    compare_field("packet_type", want.packet_type, got.packet_type);
    compare_field("packet_flags", want.packet_flags, got.packet_flags);
    compare_field("connack_code", want.connack_code, got.connack_code);
    compare_field("body_length", want.body_length, got.body_length);
  endtask

  // Check results first, then predict from the word taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_event(out_data);
      if (in_valid && in_ready) deframe_step(in_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that draws a new mode after a random countdown of cycles
  // ---------------------------------------------------------------------------
  int rx_mode = 0;
  int rx_left = 0;
  int rx_hold = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(100, 400);
    end else begin
      rx_left--;
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            rx_hold = $urandom_range(1, 20);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Drive one word at a falling edge and hold it until accepted
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data.op   <= op;
    in_data.data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_sent++;
    if (op == mqd_pkg::OP_RESTART) restarts_sent++;
  endtask

  task automatic send_random_byte();
    send_word(mqd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_restart();
    send_word(mqd_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
  endtask

  // Remaining length as 7-bit groups, low group first
  task automatic send_length(input int unsigned value, input int groups);
    logic [7:0] b;
    for (int i = 0; i < groups; i++) begin
      b[7]   = (i < groups - 1);
      b[6:0] = 7'(value >> (7 * i));
      send_word(mqd_pkg::OP_BYTE, b);
    end
  endtask

  task automatic send_packet(input logic [7:0] hdr, input int unsigned len, input int groups);
    send_word(mqd_pkg::OP_BYTE, hdr);
    send_length(len, groups);
    repeat (len) send_random_byte();
  endtask

  // Stop sending and hold off until every expected event has come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Fewest groups for a length, sometimes padded with zero groups
  function automatic int length_groups(input int unsigned len);
    int g;
    g = (len < 128) ? 1 : (len < 16384) ? 2 : (len < 2097152) ? 3 : 4;
    if ($urandom_range(0, 3) == 0) g = $urandom_range(g, 4);
    return g;
  endfunction

  function automatic bit known_type(input logic [3:0] t);
    case (t)
      mqd_pkg::TYPE_CONNACK, mqd_pkg::TYPE_PUBLISH, mqd_pkg::TYPE_PUBACK,
      mqd_pkg::TYPE_SUBACK, mqd_pkg::TYPE_UNSUBACK,
      mqd_pkg::TYPE_PINGRESP: return 1'b1;
      default:                return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // empty-body ping, classified on its length byte
    send_packet({mqd_pkg::TYPE_PINGRESP, 4'h0}, 0, 1);
    // connack reports its second body byte
    send_word(mqd_pkg::OP_BYTE, {mqd_pkg::TYPE_CONNACK, 4'h0});
    send_length(2, 1);
    send_word(mqd_pkg::OP_BYTE, 8'h00);
    send_word(mqd_pkg::OP_BYTE, 8'hff);
    send_packet({mqd_pkg::TYPE_PUBLISH, 4'hf}, 1, 1);
    send_packet({mqd_pkg::TYPE_PUBACK, 4'h2}, 2, 1);
    // empty bodies behind a padded two-group length
    send_packet({mqd_pkg::TYPE_SUBACK, 4'h0}, 0, 2);
    send_packet({mqd_pkg::TYPE_UNSUBACK, 4'h0}, 0, 2);
    // short connack halts the parser; a ping after it must be dropped
    send_packet({mqd_pkg::TYPE_CONNACK, 4'h0}, 1, 1);
    send_word(mqd_pkg::OP_BYTE, {mqd_pkg::TYPE_PINGRESP, 4'h0});
    send_word(mqd_pkg::OP_BYTE, 8'h00);
    send_restart();
    // continuation on the fourth length group
    repeat (5) send_word(mqd_pkg::OP_BYTE, 8'hff);
    send_restart();
    // reserved type
    send_packet({TYPE_RESERVED, 4'hf}, 0, 1);
    send_restart();
  endtask

  task automatic test_capacity();
    wait_drain();
    // header plus body exactly fills the buffer
    send_packet({mqd_pkg::TYPE_PUBLISH, 4'h0}, mqd_pkg::RX_CAPACITY - 3, 2);
    // one byte over: counted off, then the next byte starts a packet
    send_packet({mqd_pkg::TYPE_PUBLISH, 4'h5}, mqd_pkg::RX_CAPACITY - 2, 2);
    send_packet({mqd_pkg::TYPE_PINGRESP, 4'h0}, 0, 1);
    // largest length: dropped at once, abandoned by a restart
    send_word(mqd_pkg::OP_BYTE, {mqd_pkg::TYPE_PUBLISH, 4'ha});
    send_length(LEN_MAX, 4);
    repeat (3) send_random_byte();
    send_restart();
    // three-group header one byte over the limit
    send_word(mqd_pkg::OP_BYTE, {mqd_pkg::TYPE_SUBACK, 4'h0});
    send_length(mqd_pkg::RX_CAPACITY - 3, 3);
    send_restart();
    wait_drain();
  endtask

  task automatic test_random();
    int unsigned stop_at, len, pick, max_len;
    int          groups;
    logic [3:0]  ptype;
    bit          halts;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      pick  = $urandom_range(0, 99);
      halts = 1'b0;
      if (pick < 62) begin
        // packet of a known type; some connacks are too short and halt the parser
        case ($urandom_range(0, 5))
          0:       ptype = mqd_pkg::TYPE_CONNACK;
          1:       ptype = mqd_pkg::TYPE_PUBLISH;
          2:       ptype = mqd_pkg::TYPE_PUBACK;
          3:       ptype = mqd_pkg::TYPE_SUBACK;
          4:       ptype = mqd_pkg::TYPE_UNSUBACK;
          default: ptype = mqd_pkg::TYPE_PINGRESP;
        endcase
        if (ptype == mqd_pkg::TYPE_CONNACK) begin
          len   = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 1) : $urandom_range(2, 6);
          halts = (len < 2);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 200) : $urandom_range(0, 20);
        end
        send_packet({ptype, 4'($urandom_range(0, 15))}, len, length_groups(len));
      end else if (pick < 70) begin
        // unknown type, reported on the last byte
        ptype = 4'($urandom_range(0, 15));
        while (known_type(ptype)) ptype = 4'($urandom_range(0, 15));
        len = $urandom_range(0, 10);
        send_packet({ptype, 4'($urandom_range(0, 15))}, len, length_groups(len));
        halts = 1'b1;
      end else if (pick < 78) begin
        // length that never ends
        send_random_byte();
        repeat (4) send_word(mqd_pkg::OP_BYTE, {1'b1, 7'($urandom_range(0, 127))});
        halts = 1'b1;
      end else if (pick < 85) begin
        // oversize header, abandoned part way through the discard
        groups  = $urandom_range(2, 4);
        max_len = (32'd1 << (7 * groups)) - 1;
        len     = ($urandom_range(0, 2) == 0) ?
                  mqd_pkg::RX_CAPACITY - groups :
                  $urandom_range(mqd_pkg::RX_CAPACITY - groups, max_len);
        send_random_byte();
        send_length(len, groups);
        repeat ($urandom_range(0, 6)) send_random_byte();
        send_restart();
      end else if (pick < 90) begin
        // restart in the middle of a packet
        len = $urandom_range(3, 20);
        send_word(mqd_pkg::OP_BYTE, {mqd_pkg::TYPE_PUBLISH, 4'($urandom_range(0, 15))});
        if ($urandom_range(0, 2) != 0) begin
          send_length(len, length_groups(len));
          repeat ($urandom_range(0, len - 1)) send_random_byte();
        end
        send_restart();
      end else if (pick < 96) begin
        // raw noise, then a clean start
        repeat ($urandom_range(1, 8)) send_random_byte();
        send_restart();
      end else begin
        send_restart();
      end
      // clear a halted parser, sometimes after a few dropped bytes
      if (halts) begin
        repeat ($urandom_range(0, 5)) send_random_byte();
        send_restart();
      end
      if ($urandom_range(0, 199) == 0) wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    foreach (event_tally[i]) event_tally[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    test_random();
    wait_drain();
    $display("Covered %0d words (%0d restarts) in %0d cycles, incl. buffer-limit packets.",
             words_sent, restarts_sent, cycle_count);
    $display("Events: connack %0d, pingresp %0d, publish %0d, ack %0d, oversize %0d, error %0d",
             event_tally[mqd_pkg::EV_CONNACK], event_tally[mqd_pkg::EV_PINGRESP],
             event_tally[mqd_pkg::EV_PUBLISH], event_tally[mqd_pkg::EV_ACK],
             event_tally[mqd_pkg::EV_OVERSIZE], event_tally[mqd_pkg::EV_PROTO]);
    if (errors == 0) begin
      $display("PASS mqtt_packet_deframer");
    end else begin
      $display("FAIL mqtt_packet_deframer");
    end
    $finish;
  end

  // End a run that stops making progress
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d events still expected",
             $time, CYCLE_LIMIT, pending_events.size());
    $display("FAIL mqtt_packet_deframer");
    $finish;
  end

endmodule
